>>> hdl/spbm_pkg.sv
// Shared types and constants for the switchable program bank mapper.
`timescale 1ns / 1ps

package spbm_pkg;

   // Storage sizes
   localparam int WORK_RAM_BYTES_DEF = 8192;
   localparam int WORK_WINDOW_BYTES  = 8192;
   localparam int PATTERN_RAM_BYTES  = 8192;
   localparam int NAMETABLE_BYTES    = 2048;
   localparam int BANK_BYTES         = 16384;
   localparam int BANK_AW            = $clog2(BANK_BYTES);
   localparam int PAT_AW             = $clog2(PATTERN_RAM_BYTES);
   localparam int NT_AW              = $clog2(NAMETABLE_BYTES);
   localparam int ROM_AW             = 18;

   // CPU address map
   localparam logic [15:0] CPU_EXP_BASE   = 16'h4020;
   localparam logic [15:0] CPU_WRAM_BASE  = 16'h6000;
   localparam logic [15:0] CPU_PRG_BASE   = 16'h8000;
   localparam logic [15:0] CPU_FIXED_BASE = 16'hC000;

   // PPU address map (14-bit space)
   localparam logic [13:0] PPU_NT_BASE  = 14'h2000;
   localparam logic [13:0] PPU_PAL_BASE = 14'h3F00;

   localparam logic [7:0] FILL_BYTE = 8'hFF;

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      FUNC_CPU_RD = 2'd0,
      FUNC_CPU_WR = 2'd1,
      FUNC_PPU_RD = 2'd2,
      FUNC_PPU_WR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      SRC_DATA  = 3'd0,
      SRC_PRG   = 3'd1,
      SRC_CHR   = 3'd2,
      SRC_WRITE = 3'd3,
      SRC_ERROR = 3'd4
   } source_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_FILL,
      SEL_WORK,
      SEL_PATTERN,
      SEL_NAMETABLE
   } sel_type;

   typedef enum logic [1:0] {
      REG_PRG_BANK_COUNT = 2'd0,
      REG_CHR_IS_RAM     = 2'd1,
      REG_VERT_MIRROR    = 2'd2
   } csr_reg_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

>>> hdl/spbm_req_if.sv
// Bus access channel: one CPU or PPU access per word.
`timescale 1ns / 1ps

interface spbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] address;
   logic [7:0]  value;

   modport source (output valid, output func, output address, output value, input ready);
   modport sink   (input valid, input func, input address, input value, output ready);
endinterface

>>> hdl/spbm_rsp_if.sv
// Result channel: one result word per access.
`timescale 1ns / 1ps

interface spbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data;
   logic [2:0]  src;
   logic [17:0] rom_address;

   modport source (output valid, output data, output src, output rom_address, input ready);
   modport sink   (input valid, input data, input src, input rom_address, output ready);
endinterface

>>> hdl/switchable_prg_bank_mapper.sv
// Switchable 16 KiB program bank mapper with work, pattern and nametable RAMs.
//
//  channel  | direction | handshake      | word
//  ---------+-----------+----------------+-------------------------------
//  req_bus  | in        | valid / ready  | func, address, value
//  rsp_bus  | out       | valid / ready  | data, src, rom_address
//  csr_*    | in        | APB write/read | prg_bank_count, chr_is_ram,
//           |           |                | vertical_mirroring
//
// One access is taken per cycle unless a stalled result fills the read stage; its result
// passes the read stage, where the RAMs are read, then the output register. Memory writes
// land at the accept edge, so the next access always reads the new byte. After reset the
// RAMs are swept to zero, one entry per cycle over the largest RAM, with ready low. A
// stalled result holds in the output register while one more access waits in the read stage.
`timescale 1ns / 1ps

module switchable_prg_bank_mapper #(
   parameter int WORK_RAM_BYTES = spbm_pkg::WORK_RAM_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   spbm_req_if.sink                    req_bus,
   spbm_rsp_if.source                  rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [spbm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [spbm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [spbm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import spbm_pkg::*;

   localparam int WR_AW     = $clog2(WORK_RAM_BYTES);
   localparam int WR_FOLDS  = (WORK_WINDOW_BYTES + WORK_RAM_BYTES - 1) / WORK_RAM_BYTES - 1;
   localparam int CLR_DEPTH = (WORK_RAM_BYTES > PATTERN_RAM_BYTES) ?
                              WORK_RAM_BYTES : PATTERN_RAM_BYTES;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);
   localparam int WW_AW     = $clog2(WORK_WINDOW_BYTES);

   // Control and configuration state
   state_type          state_ff, state_in;
   logic [CLR_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [4:0]         bank_count_ff, bank_count_in;
   logic               chr_ram_ff, chr_ram_in;
   logic               vmirror_ff, vmirror_in;
   logic [3:0]         bank_ff, bank_in;
   logic               s1_v_ff, s1_v_in;
   logic               out_v_ff, out_v_in;

   // Payload registers
   sel_type            s1_sel_ff, s1_sel_in;
   source_type         s1_src_ff, s1_src_in;
   logic [ROM_AW-1:0]  s1_rom_ff, s1_rom_in;
   logic [7:0]         out_data_ff, out_data_in;
   source_type         out_src_ff;
   logic [ROM_AW-1:0]  out_rom_ff;

   // Memories
   logic [7:0] work_mem [WORK_RAM_BYTES];
   logic [7:0] pat_mem  [PATTERN_RAM_BYTES];
   logic [7:0] nt_mem   [NAMETABLE_BYTES];
   logic [7:0] wr_rd_ff, pt_rd_ff, nt_rd_ff;

   logic               clearing, clr_done;
   logic               accept, out_load, s1_free;
   logic               csr_wr;
   logic               wr_we, pt_we, nt_we, bank_we;
   logic [WR_AW-1:0]   wr_idx;
   logic [PAT_AW-1:0]  pt_idx;
   logic [NT_AW-1:0]   nt_idx;
   logic [WW_AW:0]     wr_fold;
   logic [13:0]        ppu_addr;
   logic [4:0]         fixed_bank;
   logic               wr_clr_en, nt_clr_en;

   // ------------------------------------------------------------------
   // Clear sweep sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_done) state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing   = 1'b0;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + CLR_AW'(1);
         end
         ST_RUN:  clearing = 1'b0;
         default: clearing = 1'b1;
      endcase
   end

   assign clr_done  = (clr_cnt_ff == CLR_AW'(CLR_DEPTH - 1));
   assign wr_clr_en = ({1'b0, clr_cnt_ff} < (CLR_AW + 1)'(WORK_RAM_BYTES));
   assign nt_clr_en = ({1'b0, clr_cnt_ff} < (CLR_AW + 1)'(NAMETABLE_BYTES));

   // ------------------------------------------------------------------
   // Handshake: read stage, then output register
   assign out_load = s1_v_ff && (!out_v_ff || rsp_bus.ready);
   assign s1_free  = !s1_v_ff || out_load;
   assign req_bus.ready = !clearing && s1_free;
   assign accept   = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (out_load) begin
         s1_v_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_v_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Address translation
   assign ppu_addr   = req_bus.address[13:0];
   assign fixed_bank = (bank_count_ff == 5'd0) ? 5'd0 : bank_count_ff - 5'd1;
   assign pt_idx     = ppu_addr[PAT_AW-1:0];
   // Fold the four nametable views into 2 KiB; 0x3000 mirrors 0x2000 by the low 12 bits
   assign nt_idx     = vmirror_ff ? ppu_addr[10:0] : {ppu_addr[11], ppu_addr[9:0]};

   // Work RAM offset modulo its size
   always_comb begin
      wr_fold = {1'b0, req_bus.address[WW_AW-1:0]};
      for (int i = 0; i < WR_FOLDS; i++) begin
         if (wr_fold >= (WW_AW + 1)'(WORK_RAM_BYTES)) begin
            wr_fold = wr_fold - (WW_AW + 1)'(WORK_RAM_BYTES);
         end
      end
   end
   assign wr_idx = wr_fold[WR_AW-1:0];

   // Decode one access
   always_comb begin
      s1_sel_in = SEL_ZERO;
      s1_src_in = SRC_DATA;
      s1_rom_in = '0;
      wr_we     = 1'b0;
      pt_we     = 1'b0;
      nt_we     = 1'b0;
      bank_we   = 1'b0;
      case (func_type'(req_bus.func))
         FUNC_CPU_RD: begin
            if (req_bus.address < CPU_EXP_BASE) begin
               s1_src_in = SRC_ERROR;
            end else if (req_bus.address < CPU_WRAM_BASE) begin
               s1_sel_in = SEL_FILL;
            end else if (req_bus.address < CPU_PRG_BASE) begin
               s1_sel_in = SEL_WORK;
            end else if (req_bus.address < CPU_FIXED_BASE) begin
               s1_src_in = SRC_PRG;
               s1_rom_in = {bank_ff, req_bus.address[BANK_AW-1:0]};
            end else begin
               s1_src_in = SRC_PRG;
               s1_rom_in = {fixed_bank[3:0], req_bus.address[BANK_AW-1:0]};
            end
         end
         FUNC_CPU_WR: begin
            s1_src_in = SRC_WRITE;
            if (req_bus.address >= CPU_PRG_BASE) begin
               bank_we = 1'b1;
            end else if (req_bus.address >= CPU_WRAM_BASE) begin
               wr_we = 1'b1;
            end
         end
         FUNC_PPU_RD: begin
            if (ppu_addr < PPU_NT_BASE) begin
               if (chr_ram_ff) begin
                  s1_sel_in = SEL_PATTERN;
               end else begin
                  s1_src_in = SRC_CHR;
                  s1_rom_in = ROM_AW'(ppu_addr);
               end
            end else if (ppu_addr < PPU_PAL_BASE) begin
               s1_sel_in = SEL_NAMETABLE;
            end else begin
               s1_src_in = SRC_ERROR;
            end
         end
         FUNC_PPU_WR: begin
            s1_src_in = SRC_WRITE;
            if (ppu_addr < PPU_NT_BASE) begin
               pt_we = chr_ram_ff;
            end else if (ppu_addr < PPU_PAL_BASE) begin
               nt_we = 1'b1;
            end
         end
         default: s1_src_in = SRC_ERROR;
      endcase
   end

   // ------------------------------------------------------------------
   // Memories: clear sweep or access write, read on accept
   always_ff @(posedge clock) begin
      if (clearing && wr_clr_en) begin
         work_mem[clr_cnt_ff[WR_AW-1:0]] <= '0;
      end else if (accept && wr_we) begin
         work_mem[wr_idx] <= req_bus.value;
      end
      if (accept) begin
         wr_rd_ff <= work_mem[wr_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         pat_mem[clr_cnt_ff[PAT_AW-1:0]] <= '0;
      end else if (accept && pt_we) begin
         pat_mem[pt_idx] <= req_bus.value;
      end
      if (accept) begin
         pt_rd_ff <= pat_mem[pt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing && nt_clr_en) begin
         nt_mem[clr_cnt_ff[NT_AW-1:0]] <= '0;
      end else if (accept && nt_we) begin
         nt_mem[nt_idx] <= req_bus.value;
      end
      if (accept) begin
         nt_rd_ff <= nt_mem[nt_idx];
      end
   end

   // Pick the result byte
   always_comb begin
      case (s1_sel_ff)
         SEL_ZERO:      out_data_in = '0;
         SEL_FILL:      out_data_in = FILL_BYTE;
         SEL_WORK:      out_data_in = wr_rd_ff;
         SEL_PATTERN:   out_data_in = pt_rd_ff;
         SEL_NAMETABLE: out_data_in = nt_rd_ff;
         default:       out_data_in = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      bank_count_in = bank_count_ff;
      chr_ram_in    = chr_ram_ff;
      vmirror_in    = vmirror_ff;
      if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[3:2]))
            REG_PRG_BANK_COUNT: bank_count_in = csr_pwdata[4:0];
            REG_CHR_IS_RAM:     chr_ram_in    = csr_pwdata[0];
            REG_VERT_MIRROR:    vmirror_in    = csr_pwdata[0];
            default:            bank_count_in = bank_count_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_PRG_BANK_COUNT: csr_prdata = CSR_DW'(bank_count_ff);
         REG_CHR_IS_RAM:     csr_prdata = CSR_DW'(chr_ram_ff);
         REG_VERT_MIRROR:    csr_prdata = CSR_DW'(vmirror_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Bank register loads on CPU writes into ROM space
   assign bank_in = (accept && bank_we) ? req_bus.value[3:0] : bank_ff;

   // ------------------------------------------------------------------
   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         bank_count_ff <= 5'd1;
         chr_ram_ff    <= 1'b1;
         vmirror_ff    <= 1'b0;
         bank_ff       <= '0;
         s1_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         bank_count_ff <= bank_count_in;
         chr_ram_ff    <= chr_ram_in;
         vmirror_ff    <= vmirror_in;
         bank_ff       <= bank_in;
         s1_v_ff       <= s1_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   // Payload registers: advance on accept and on output load
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sel_ff <= s1_sel_in;
         s1_src_ff <= s1_src_in;
         s1_rom_ff <= s1_rom_in;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
         out_src_ff  <= s1_src_ff;
         out_rom_ff  <= s1_rom_ff;
      end
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.data        = out_data_ff;
   assign rsp_bus.src         = out_src_ff;
   assign rsp_bus.rom_address = out_rom_ff;

endmodule

>>> hdl/spbm_checker.sv
// Port-level checks for the mapper and their binding to the top level.
`timescale 1ns / 1ps

module spbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data,
   input logic [2:0]  rsp_source,
   input logic [17:0] rsp_rom_address
);
   import spbm_pkg::*;

   // Hold off accesses while the RAMs are swept after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("access accepted right after reset");

   // Hold a stalled result word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) &&
                                  $stable(rsp_source) && $stable(rsp_rom_address))
      else $error("stalled result changed");

   // Write and error results carry no byte and no ROM offset
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_source == SRC_WRITE || rsp_source == SRC_ERROR) |->
         rsp_data == 8'h00 && rsp_rom_address == '0)
      else $error("write or error result carries payload");

   // Character ROM fetches stay inside the 8 KiB pattern space
   a_chr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source == SRC_CHR |-> rsp_rom_address[17:13] == '0 &&
                                             rsp_data == 8'h00)
      else $error("character ROM offset out of pattern space");

   // ROM fetches return no data byte
   a_prg_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source == SRC_PRG |-> rsp_data == 8'h00)
      else $error("program ROM fetch carries a data byte");

endmodule

bind switchable_prg_bank_mapper spbm_checker u_spbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_data        (rsp_bus.data),
   .rsp_source      (rsp_bus.src),
   .rsp_rom_address (rsp_bus.rom_address)
);

>>> sim/tb.sv
// Self-checking testbench for the switchable program bank mapper.
`timescale 1ns / 1ps

module tb;
   import spbm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1300;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      func_type    func;
      logic [15:0] address;
      logic [7:0]  value;
   } bus_access_type;

   typedef struct packed {
      logic [7:0]        data;
      source_type        source;
      logic [ROM_AW-1:0] rom_address;
   } mapper_result_type;

   logic clock;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   spbm_req_if req_bus ();
   spbm_rsp_if rsp_bus ();

   switchable_prg_bank_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mapper image kept by the testbench
   logic [4:0] cfg_bank_count;
   logic       cfg_chr_ram;
   logic       cfg_vert_mirror;
   logic [3:0] bank_sel;
   logic [7:0] work_mem      [WORK_RAM_BYTES_DEF];
   logic [7:0] pattern_mem   [PATTERN_RAM_BYTES];
   logic [7:0] nametable_mem [NAMETABLE_BYTES];

   bus_access_type    pending_accesses[$];
   mapper_result_type predicted_responses[$];

   int mismatch_count;
   int cycle_count;
   int burst_left;
   int gap_left;
   int stall_mode;
   int mode_left;

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Fold a PPU nametable address into the 2 KiB store by mirroring mode
   function automatic logic [NT_AW-1:0] fold_nametable(logic [13:0] addr);
      logic [13:0] a;
      a = addr;
      if (a > 14'h2FFF) a = a - 14'h1000;
      if (cfg_vert_mirror) begin
         if (a > 14'h27FF) a = a - 14'h800;
      end else if (a > 14'h23FF && a < 14'h2800) begin
         a = a - 14'h400;
      end else if (a > 14'h27FF && a < 14'h2C00) begin
         a = a - 14'h400;
      end else if (a > 14'h2BFF) begin
         a = a - 14'h800;
      end
      return a[NT_AW-1:0];
   endfunction

   // Work out the response to one bus access and apply its side effects
   function automatic mapper_result_type map_access(bus_access_type acc);
      mapper_result_type r;
      logic [13:0]       ppu_addr;
      logic [NT_AW-1:0]  nt_idx;
      int                banks;
      r.data        = 8'h00;
      r.source      = SRC_DATA;
      r.rom_address = '0;
      ppu_addr      = acc.address[13:0];
      if (acc.func == FUNC_CPU_RD) begin
         if (acc.address < CPU_EXP_BASE) begin
            r.source = SRC_ERROR;
         end else if (acc.address < CPU_WRAM_BASE) begin
            r.data = FILL_BYTE;
         end else if (acc.address < CPU_PRG_BASE) begin
            r.data = work_mem[acc.address[12:0]];
         end else if (acc.address < CPU_FIXED_BASE) begin
            r.source      = SRC_PRG;
            r.rom_address = {bank_sel, acc.address[13:0]};
         end else begin
            // a zero count counts as one bank; large counts wrap to 18 bits
            banks         = (cfg_bank_count == 5'd0) ? 1 : int'(cfg_bank_count);
            r.source      = SRC_PRG;
            r.rom_address = ROM_AW'((banks - 1) * BANK_BYTES + int'(acc.address[13:0]));
         end
      end else if (acc.func == FUNC_CPU_WR) begin
         r.source = SRC_WRITE;
         if (acc.address >= CPU_WRAM_BASE && acc.address < CPU_PRG_BASE)
            work_mem[acc.address[12:0]] = acc.value;
         else if (acc.address >= CPU_PRG_BASE)
            bank_sel = acc.value[3:0];
      end else if (ppu_addr < PPU_NT_BASE) begin
         if (acc.func == FUNC_PPU_WR) begin
            r.source = SRC_WRITE;
            if (cfg_chr_ram) pattern_mem[ppu_addr[PAT_AW-1:0]] = acc.value;
         end else if (cfg_chr_ram) begin
            r.data = pattern_mem[ppu_addr[PAT_AW-1:0]];
         end else begin
            r.source      = SRC_CHR;
            r.rom_address = ROM_AW'(ppu_addr);
         end
      end else if (ppu_addr < PPU_PAL_BASE) begin
         nt_idx = fold_nametable(ppu_addr);
         if (acc.func == FUNC_PPU_WR) begin
            r.source              = SRC_WRITE;
            nametable_mem[nt_idx] = acc.value;
         end else begin
            r.data = nametable_mem[nt_idx];
         end
      end else begin
         // palette space: reads are errors, writes are dropped
         r.source = (acc.func == FUNC_PPU_WR) ? SRC_WRITE : SRC_ERROR;
      end
      return r;
   endfunction

   // Pick a small set of offsets so that reads often hit bytes written before
   function automatic logic [12:0] hot_offset();
      return 13'(($urandom_range(0, 3) << 11) | $urandom_range(0, 7));
   endfunction

   function automatic bus_access_type random_access();
      bus_access_type acc;
      int             pick;
      acc.func  = func_type'($urandom_range(0, 3));
      acc.value = 8'($urandom);
      pick      = $urandom_range(0, 9);
      if (acc.func == FUNC_CPU_RD || acc.func == FUNC_CPU_WR) begin
         case (pick)
            0: acc.address = 16'($urandom);
            1: acc.address = 16'($urandom_range(0, 16'h5FFF));
            2, 3, 4: acc.address = CPU_WRAM_BASE + 16'(hot_offset());
            5: acc.address = 16'($urandom_range(16'h6000, 16'h7FFF));
            6, 7: acc.address = 16'($urandom_range(16'h8000, 16'hBFFF));
            default: acc.address = 16'($urandom_range(16'hC000, 16'hFFFF));
         endcase
      end else begin
         // the PPU ignores the top two address bits; let them toggle anyway
         acc.address[15:14] = 2'($urandom);
         case (pick)
            0: acc.address[13:0] = 14'($urandom);
            1, 2: acc.address[13:0] = 14'(hot_offset());
            3: acc.address[13:0] = 14'($urandom_range(0, 14'h1FFF));
            4, 5, 6: acc.address[13:0] = PPU_NT_BASE
                        + 14'(($urandom_range(0, 6) << 10) | $urandom_range(0, 7));
            7: acc.address[13:0] = 14'($urandom_range(14'h2000, 14'h3EFF));
            8: acc.address[13:0] = 14'($urandom_range(14'h3F00, 14'h3FFF));
            default: acc.address[13:0] = 14'($urandom_range(14'h2000, 14'h2FFF));
         endcase
      end
      return acc;
   endfunction

   task automatic queue_access(func_type f, logic [15:0] addr, logic [7:0] val);
      bus_access_type acc;
      acc.func    = f;
      acc.address = addr;
      acc.value   = val;
      pending_accesses.push_back(acc);
   endtask

   // Hold until every access is sent and answered, then let the pipeline settle
   task automatic wait_bus_quiet();
      while (pending_accesses.size() != 0 || req_bus.valid
             || predicted_responses.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(csr_reg_type idx, logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PRG_BANK_COUNT: cfg_bank_count  = val[4:0];
         REG_CHR_IS_RAM:     cfg_chr_ram     = val[0];
         REG_VERT_MIRROR:    cfg_vert_mirror = val[0];
         default: ;
      endcase
   endtask

   task automatic set_mapper(logic [4:0] banks, logic chr_ram, logic vert);
      csr_write(REG_PRG_BANK_COUNT, CSR_DW'(banks));
      csr_write(REG_CHR_IS_RAM, CSR_DW'(chr_ram));
      csr_write(REG_VERT_MIRROR, CSR_DW'(vert));
   endtask

   // Sender: bursts of random length with random gaps
   always @(posedge clock) begin
      bus_access_type nxt;
      logic           send;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         send = 1'b0;
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_accesses.size() != 0) begin
            nxt             = pending_accesses.pop_front();
            send            = 1'b1;
            req_bus.func    <= nxt.func;
            req_bus.address <= nxt.address;
            req_bus.value   <= nxt.value;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
         req_bus.valid <= send;
      end
   end

   // Receiver: switch between always ready, coin-flip and mostly stalled
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode    <= 0;
         mode_left     <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 150);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: predict on each accepted access word, check each result word
   always @(posedge clock) begin
      bus_access_type    acc;
      mapper_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            acc.func    = func_type'(req_bus.func);
            acc.address = req_bus.address;
            acc.value   = req_bus.value;
            predicted_responses.push_back(map_access(acc));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_responses.size() == 0) begin
               $display("%0t: unexpected result word data=%h source=%0d rom_address=%h",
                        $time, rsp_bus.data, rsp_bus.src, rsp_bus.rom_address);
               mismatch_count++;
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_bus.data !== want.data) begin
                  $display("%0t: data mismatch, expected %h, got %h",
                           $time, want.data, rsp_bus.data);
                  mismatch_count++;
               end
               if (rsp_bus.src !== want.source) begin
                  $display("%0t: source mismatch, expected %0d, got %0d",
                           $time, want.source, rsp_bus.src);
                  mismatch_count++;
               end
               if (rsp_bus.rom_address !== want.rom_address) begin
                  $display("%0t: rom_address mismatch, expected %h, got %h",
                           $time, want.rom_address, rsp_bus.rom_address);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [4:0] banks;
      logic       chr_ram;
      logic       vert;

      // Drive every input known from time zero
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_CPU_RD;
      req_bus.address = '0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      cfg_bank_count  = 5'd1;
      cfg_chr_ram     = 1'b1;
      cfg_vert_mirror = 1'b0;
      bank_sel        = 4'd0;
      foreach (work_mem[i]) work_mem[i] = 8'h00;
      foreach (pattern_mem[i]) pattern_mem[i] = 8'h00;
      foreach (nametable_mem[i]) nametable_mem[i] = 8'h00;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Hold until the RAM clearing sweep is over
      do @(negedge clock); while (!req_bus.ready);

      // Directed: register reset settings, every region edge
      queue_access(FUNC_CPU_RD, 16'h0000, 8'h00);
      queue_access(FUNC_CPU_RD, 16'h401F, 8'hFF);
      queue_access(FUNC_CPU_RD, 16'h4020, 8'h00);
      queue_access(FUNC_CPU_RD, 16'h5FFF, 8'h00);
      queue_access(FUNC_CPU_WR, 16'h5FFF, 8'hAA);
      queue_access(FUNC_CPU_WR, 16'h6000, 8'h5A);
      queue_access(FUNC_CPU_RD, 16'h6000, 8'h00);
      queue_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);
      queue_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);
      queue_access(FUNC_CPU_WR, 16'hFFFF, 8'hFF);
      queue_access(FUNC_CPU_RD, 16'h8000, 8'h00);
      queue_access(FUNC_CPU_RD, 16'hBFFF, 8'h00);
      queue_access(FUNC_CPU_RD, 16'hC000, 8'h00);
      queue_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
      queue_access(FUNC_PPU_WR, 16'h1FFF, 8'h3C);
      queue_access(FUNC_PPU_RD, 16'hDFFF, 8'h00);
      queue_access(FUNC_PPU_WR, 16'h2401, 8'h77);
      queue_access(FUNC_PPU_RD, 16'h2001, 8'h00);
      queue_access(FUNC_PPU_RD, 16'h3001, 8'h00);
      queue_access(FUNC_PPU_WR, 16'h3FFF, 8'h12);
      queue_access(FUNC_PPU_RD, 16'h3F00, 8'h00);
      queue_access(FUNC_CPU_WR, 16'h8000, 8'h00);
      wait_bus_quiet();

      // Directed: character ROM, vertical mirroring, zero bank count
      set_mapper(5'd0, 1'b0, 1'b1);
      queue_access(FUNC_PPU_RD, 16'h1FFF, 8'h00);
      queue_access(FUNC_PPU_WR, 16'h0000, 8'h55);
      queue_access(FUNC_CPU_RD, 16'hC000, 8'h00);
      queue_access(FUNC_PPU_RD, 16'h2801, 8'h00);
      wait_bus_quiet();

      // Random phases, the first few at the extremes of the settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin banks = 5'd16; chr_ram = 1'b0; vert = 1'b1; end
            1: begin banks = 5'd31; chr_ram = 1'b1; vert = 1'b0; end
            2: begin banks = 5'd0;  chr_ram = 1'b0; vert = 1'b0; end
            3: begin banks = 5'd1;  chr_ram = 1'b1; vert = 1'b1; end
            default: begin
               banks   = 5'($urandom_range(0, 31));
               chr_ram = 1'($urandom_range(0, 1));
               vert    = 1'($urandom_range(0, 1));
            end
         endcase
         set_mapper(banks, chr_ram, vert);
         for (int n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++)
            pending_accesses.push_back(random_access());
         wait_bus_quiet();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && predicted_responses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
